// File: hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;
  localparam int unsigned CAPACITY_DEF = 16;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_UPDATE = 2'd2;
  localparam logic [1:0] MODE_LIST   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  entry_tag;
    logic [7:0]  severity;
    logic [15:0] arrival;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_tag;
    logic [7:0]  out_severity;
    logic [15:0] out_arrival;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [7:0]  sev;
    logic [15:0] arr;
  } entry_t;

  // Entry a goes ahead of (or with) entry b when it sorts at or before it.
  function automatic logic ahead(entry_t a, entry_t b);
    ahead = (a.sev > b.sev) || ((a.sev == b.sev) && (a.arr <= b.arr));
  endfunction
endpackage

// File: hdl/spq_if.sv
// Valid/ready channel interfaces for requests and responses.
interface spq_req_if;
  logic          valid;
  logic          ready;
  spq_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spq_rsp_if;
  logic          valid;
  logic          ready;
  spq_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue.
//   channel | dir | payload
//   req     | in  | mode, entry_tag, severity, arrival
//   rsp     | out | status, out_tag, out_severity, out_arrival, last
// A request is registered in the command queue before it reaches the back end. Insert and
// pop are done in the back end's idle state; update removes, then reinserts (S_REINS), then
// turns around (S_OUT); list sets up, reads one slot per result, then turns around.
// A two-entry command queue lets requests arrive while the back end works.
// Synchronous reset empties the queue; stalls on rsp hold the back end.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);
  logic          cmd_valid;
  logic          cmd_pop;
  spq_pkg::req_t cmd;

  spq_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  spq_back #(.CAPACITY(CAPACITY)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_pop(cmd_pop), .rsp(rsp)
  );
endmodule

// File: hdl/spq_front.sv
// Front end: two-entry command queue between the request channel and the back end.
module spq_front (
  input  logic         clk,
  input  logic         rst,
  spq_req_if.sink      req,
  output logic         cmd_valid,
  output spq_pkg::req_t cmd,
  input  logic         cmd_pop
);
  spq_pkg::req_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign req.ready = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      q[wr_ptr] <= req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (req.valid && req.ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(req.valid && req.ready) - 2'(cmd_pop);
    end
  end
endmodule

// File: hdl/spq_back.sv
// Back end: sorted register array with shift insert/remove and list walk.
module spq_back #(
  parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  spq_pkg::req_t cmd,
  output logic          cmd_pop,
  spq_rsp_if.source     rsp
);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_REINS  = 4'b0010,
    S_LIST   = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t            state;
  spq_pkg::entry_t   slot [CAPACITY];
  logic [CW-1:0]     count;
  logic [CW-1:0]     walk;
  spq_pkg::entry_t   hold;
  spq_pkg::rsp_t     out_reg;
  logic              out_valid;

  logic              out_free;
  logic              out_load;
  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] before_new;
  logic              found;
  logic [IW-1:0]     hit_pos;
  spq_pkg::entry_t   ins_word;
  logic              do_ins;
  logic              do_rem;
  logic [IW-1:0]     rem_pos;
  spq_pkg::entry_t   new_word;

  function automatic spq_pkg::rsp_t err_rsp(logic [1:0] st);
    err_rsp = '{status: st, out_tag: 8'd0, out_severity: 8'd0, out_arrival: 16'd0,
                last: 1'b1};
  endfunction

  assign out_free  = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_reg;

  assign new_word = '{tag: cmd.entry_tag, sev: cmd.severity, arr: cmd.arrival};

  always_comb begin
    found   = 1'b0;
    hit_pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      hit[i] = (CW'(i) < count) && (slot[i].tag == cmd.entry_tag);
      if (hit[i]) begin
        found   = 1'b1;
        hit_pos = IW'(i);
      end
    end
  end

  // Insert positions for the word to insert (new or held), count already valid for it.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      before_new[i] = (CW'(i) < count) && spq_pkg::ahead(slot[i], ins_word);
    end
  end

  always_comb begin
    cmd_pop  = 1'b0;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    rem_pos  = '0;
    ins_word = hold;
    out_load = 1'b0;
    if (state == S_IDLE && cmd_valid && out_free) begin
      cmd_pop  = 1'b1;
      out_load = 1'b1;
      case (cmd.mode)
        spq_pkg::MODE_INSERT: begin
          ins_word = new_word;
          do_ins   = (count < CW'(CAPACITY));
        end
        spq_pkg::MODE_POP: begin
          do_rem = (count != '0);
        end
        spq_pkg::MODE_UPDATE: begin
          do_rem   = found;
          rem_pos  = hit_pos;
          out_load = !found;
        end
        default: begin
          out_load = (count == '0);
        end
      endcase
    end else if (state == S_REINS) begin
      do_ins   = 1'b1;
      out_load = 1'b1;
    end else if (state == S_LIST) begin
      out_load = out_free;
    end
  end

  always_ff @(posedge clk) begin
    if (do_rem) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (IW'(i) >= rem_pos) begin
          slot[i] <= slot[i + 1];
        end
      end
    end else if (do_ins) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (!before_new[i]) begin
          if (i == 0 || before_new[(i == 0) ? 0 : i - 1]) begin
            slot[i] <= ins_word;
          end else begin
            slot[i] <= slot[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_pop && cmd.mode == spq_pkg::MODE_UPDATE) begin
      hold <= '{tag: cmd.entry_tag, sev: cmd.severity, arr: slot[hit_pos].arr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      walk      <= '0;
      out_reg   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            case (cmd.mode)
              spq_pkg::MODE_INSERT: begin
                if (do_ins) begin
                  count   <= count + CW'(1);
                  out_reg <= '{status: spq_pkg::ST_OK, out_tag: cmd.entry_tag,
                               out_severity: cmd.severity, out_arrival: cmd.arrival,
                               last: 1'b1};
                end else begin
                  out_reg <= err_rsp(spq_pkg::ST_FULL);
                end
              end
              spq_pkg::MODE_POP: begin
                if (do_rem) begin
                  count   <= count - CW'(1);
                  out_reg <= '{status: spq_pkg::ST_OK, out_tag: slot[0].tag,
                               out_severity: slot[0].sev, out_arrival: slot[0].arr,
                               last: 1'b1};
                end else begin
                  out_reg <= err_rsp(spq_pkg::ST_EMPTY);
                end
              end
              spq_pkg::MODE_UPDATE: begin
                if (count == '0) begin
                  out_reg <= err_rsp(spq_pkg::ST_EMPTY);
                end else if (!found) begin
                  out_reg <= err_rsp(spq_pkg::ST_NOTFOUND);
                end else begin
                  count     <= count - CW'(1);
                  state     <= S_REINS;
                end
              end
              default: begin
                if (count == '0) begin
                  out_reg <= err_rsp(spq_pkg::ST_EMPTY);
                end else begin
                  walk      <= '0;
                  state     <= S_LIST;
                end
              end
            endcase
          end
        end
        S_REINS: begin
          count     <= count + CW'(1);
          out_reg   <= '{status: spq_pkg::ST_OK, out_tag: hold.tag, out_severity: hold.sev,
                         out_arrival: hold.arr, last: 1'b1};
          state     <= S_OUT;
        end
        S_LIST: begin
          if (out_free) begin
            out_reg   <= '{status: spq_pkg::ST_OK, out_tag: slot[walk[IW-1:0]].tag,
                           out_severity: slot[walk[IW-1:0]].sev,
                           out_arrival: slot[walk[IW-1:0]].arr,
                           last: (walk + CW'(1) == count)};
            walk      <= walk + CW'(1);
            if (walk + CW'(1) == count) begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input spq_pkg::rsp_t rsp_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != spq_pkg::ST_OK |->
      rsp_data.out_tag == 8'd0 && rsp_data.out_severity == 8'd0 &&
      rsp_data.out_arrival == 16'd0)
    else $error("error response carries data");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != spq_pkg::ST_OK |-> rsp_data.last)
    else $error("error response not last");

  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response after reset");
endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk(clk), .rst(rst), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_data(rsp.data)
);

// File: tb/sv/tb_sorted_priority_queue.sv
// Testbench for the sorted priority queue: directed and random traffic checked against a queue predictor.
`timescale 1ns / 100ps

class spq_scoreboard;
  spq_pkg::entry_t      slots[$];
  spq_pkg::rsp_t        pending[$];
  int                   errors;

  function void place(spq_pkg::entry_t e);
    int pos;
    pos = 0;
    while (pos < slots.size() && spq_pkg::ahead(slots[pos], e)) pos++;
    slots.insert(pos, e);
  endfunction

  function void push_rsp(logic [1:0] st, spq_pkg::entry_t e, logic lst);
    spq_pkg::rsp_t r;
    r.status = st;
    if (st == spq_pkg::ST_OK) begin
      r.out_tag = e.tag;
      r.out_severity = e.sev;
      r.out_arrival = e.arr;
    end else begin
      r.out_tag = '0;
      r.out_severity = '0;
      r.out_arrival = '0;
    end
    r.last = lst;
    pending.push_back(r);
  endfunction

  function void note_request(spq_pkg::req_t q);
    spq_pkg::entry_t e;
    int i;
    e.tag = q.entry_tag;
    e.sev = q.severity;
    e.arr = q.arrival;
    case (q.mode)
      spq_pkg::MODE_INSERT: begin
        if (slots.size() >= spq_pkg::CAPACITY_DEF) begin
          push_rsp(spq_pkg::ST_FULL, e, 1'b1);
        end else begin
          place(e);
          push_rsp(spq_pkg::ST_OK, e, 1'b1);
        end
      end
      spq_pkg::MODE_POP: begin
        if (slots.size() == 0) begin
          push_rsp(spq_pkg::ST_EMPTY, e, 1'b1);
        end else begin
          push_rsp(spq_pkg::ST_OK, slots.pop_front(), 1'b1);
        end
      end
      spq_pkg::MODE_UPDATE: begin
        if (slots.size() == 0) begin
          push_rsp(spq_pkg::ST_EMPTY, e, 1'b1);
        end else begin
          for (i = 0; i < slots.size(); i++)
            if (slots[i].tag == q.entry_tag) break;
          if (i == slots.size()) begin
            push_rsp(spq_pkg::ST_NOTFOUND, e, 1'b1);
          end else begin
            e.arr = slots[i].arr;
            slots.delete(i);
            place(e);
            push_rsp(spq_pkg::ST_OK, e, 1'b1);
          end
        end
      end
      default: begin
        if (slots.size() == 0) begin
          push_rsp(spq_pkg::ST_EMPTY, e, 1'b1);
        end else begin
          foreach (slots[k]) push_rsp(spq_pkg::ST_OK, slots[k], k == slots.size() - 1);
        end
      end
    endcase
  endfunction

  function void check_rsp(spq_pkg::rsp_t r);
    spq_pkg::rsp_t x;
    if (pending.size() == 0) begin
      $error("unexpected response %h", r);
      errors++;
      return;
    end
    x = pending.pop_front();
    if (r.status !== x.status) begin
      $error("status exp %0d got %0d", x.status, r.status); errors++;
    end
    if (r.out_tag !== x.out_tag) begin
      $error("out_tag exp %0d got %0d", x.out_tag, r.out_tag); errors++;
    end
    if (r.out_severity !== x.out_severity) begin
      $error("out_severity exp %0d got %0d", x.out_severity, r.out_severity); errors++;
    end
    if (r.out_arrival !== x.out_arrival) begin
      $error("out_arrival exp %0d got %0d", x.out_arrival, r.out_arrival); errors++;
    end
    if (r.last !== x.last) begin
      $error("last exp %0d got %0d", x.last, r.last); errors++;
    end
  endfunction
endclass

module tb_sorted_priority_queue;
  logic clk = 1'b0;
  logic rst = 1'b1;
  spq_req_if req ();
  spq_rsp_if rsp ();

  spq_scoreboard sb = new();
  int src_idle;
  int snk_stall;
  int cycles;
  logic [7:0] tag_pool[4];

  sorted_priority_queue u_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    src_idle = 0;
    snk_stall = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && rsp.valid && rsp.ready) sb.check_rsp(rsp.data);
    if (cycles > 400000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) rsp.ready <= ($urandom_range(99) >= snk_stall);

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(logic [1:0] m, logic [7:0] t, logic [7:0] s, logic [15:0] a);
    spq_pkg::req_t q;
    while ($urandom_range(99) < src_idle) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    q.mode = m;
    q.entry_tag = t;
    q.severity = s;
    q.arrival = a;
    req.data <= q;
    req.valid <= 1'b1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(q);
    @(negedge clk);
  endtask

  task automatic send_random();
    int r;
    logic [1:0] m;
    logic [7:0] t;
    r = $urandom_range(99);
    if (sb.slots.size() < 4) m = (r < 70) ? spq_pkg::MODE_INSERT : 2'($urandom);
    else if (sb.slots.size() > 13) m = (r < 25) ? spq_pkg::MODE_INSERT : 2'($urandom);
    else m = 2'($urandom);
    t = ($urandom_range(3) == 0) ? 8'($urandom) : tag_pool[$urandom_range(3)];
    send(m, t, ($urandom_range(3) == 0) ? 8'($urandom_range(2)) : 8'($urandom),
         ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom));
  endtask

  initial begin
    cycles = 0;
    tag_pool = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // directed: empty cases, ties, extremes, full
    send(spq_pkg::MODE_POP, 8'h00, 8'h00, 16'h0000);
    send(spq_pkg::MODE_UPDATE, 8'h11, 8'h00, 16'h0000);
    send(spq_pkg::MODE_LIST, 8'h00, 8'h00, 16'h0000);
    send(spq_pkg::MODE_INSERT, 8'hFF, 8'hFF, 16'hFFFF);
    send(spq_pkg::MODE_INSERT, 8'h00, 8'h00, 16'h0000);
    send(spq_pkg::MODE_INSERT, 8'h5A, 8'hFF, 16'hFFFF);
    send(spq_pkg::MODE_INSERT, 8'hA5, 8'hFF, 16'h0000);
    send(spq_pkg::MODE_UPDATE, 8'h77, 8'h10, 16'h0000);
    send(spq_pkg::MODE_UPDATE, 8'h00, 8'hFF, 16'h1234);
    send(spq_pkg::MODE_LIST, 8'h00, 8'h00, 16'h0000);
    for (int i = 0; i < 13; i++) send(spq_pkg::MODE_INSERT, 8'(i), 8'h80, 16'h8000);
    send(spq_pkg::MODE_LIST, 8'h00, 8'h00, 16'h0000);
    send(spq_pkg::MODE_POP, 8'h00, 8'h00, 16'h0000);
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 69; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 69; end
        default: begin src_idle = 17; snk_stall = 17; end
      endcase
      repeat (60) send_random();
    end
    req.valid <= 1'b0;
    src_idle = 0;
    snk_stall = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// File: filelist.f
hdl/spq_pkg.sv
hdl/spq_if.sv
hdl/spq_front.sv
hdl/spq_back.sv
hdl/sorted_priority_queue.sv
hdl/spq_checker.sv
tb/sv/tb_sorted_priority_queue.sv
